### rtl/core/pcc_pkg.sv
// Shared types, constants and helper functions for the calendar counter.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

    localparam int unsigned CNT_W   = 8;
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned TOTAL_W = 32;
    localparam int unsigned FLAG_W  = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEC_PER_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PER_HOUR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOUR_PER_DAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY_PER_WEEK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEK_PER_MON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_PER_YEAR  = 3'd5;

    // Reset moduli
    localparam logic [CNT_W-1:0] RST_SEC_PER_MIN  = 8'd60;
    localparam logic [CNT_W-1:0] RST_MIN_PER_HOUR = 8'd60;
    localparam logic [CNT_W-1:0] RST_HOUR_PER_DAY = 8'd24;
    localparam logic [CNT_W-1:0] RST_DAY_PER_WEEK = 8'd7;
    localparam logic [CNT_W-1:0] RST_WEEK_PER_MON = 8'd4;
    localparam logic [CNT_W-1:0] RST_MON_PER_YEAR = 8'd12;

    // Request kinds
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // Phase flag bit positions
    localparam int unsigned FLAG_NIGHT     = 0;
    localparam int unsigned FLAG_MORNING   = 1;
    localparam int unsigned FLAG_AFTERNOON = 2;
    localparam int unsigned FLAG_EVENING   = 3;
    localparam int unsigned FLAG_SLEEP     = 4;

    // 23H/24 = ((23H) >> 3) / 3; the divide by three is a reciprocal
    // multiply, exact for dividends below 2048.
    localparam logic [4:0]  LATE_NUM    = 5'd23;
    localparam logic [9:0]  DIV3_RECIP  = 10'd683;
    localparam int unsigned DIV3_SHIFT  = 11;

    typedef struct packed {
        logic              kind;
        logic [CNT_W-1:0]  set_seconds;
        logic [CNT_W-1:0]  set_minutes;
        logic [CNT_W-1:0]  set_hours;
        logic [CNT_W-1:0]  set_days;
        logic [CNT_W-1:0]  set_weeks;
        logic [CNT_W-1:0]  set_months;
        logic [YEAR_W-1:0] set_years;
    } t_in_req;

    typedef struct packed {
        logic [CNT_W-1:0]   cur_seconds;
        logic [CNT_W-1:0]   cur_minutes;
        logic [CNT_W-1:0]   cur_hours;
        logic [CNT_W-1:0]   cur_days;
        logic [CNT_W-1:0]   cur_weeks;
        logic [CNT_W-1:0]   cur_months;
        logic [YEAR_W-1:0]  cur_years;
        logic [TOTAL_W-1:0] elapsed_seconds;
        logic [FLAG_W-1:0]  phase_flags;
    } t_out_rsp;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             carry;
    } t_stage;

    // Add one modulo 256; only an exact match with the modulus clears and carries.
    function automatic t_stage stage_step(input logic [CNT_W-1:0] count,
                                          input logic [CNT_W-1:0] modulus);
        t_stage           res;
        logic [CNT_W-1:0] nxt;
        nxt = count + 8'd1;
        if (nxt == modulus) begin
            res.count = '0;
            res.carry = 1'b1;
        end else begin
            res.count = nxt;
            res.carry = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [FLAG_W-1:0] phase_bits(input logic [CNT_W-1:0] h,
                                                     input logic [CNT_W-1:0] hpd);
        logic [FLAG_W-1:0] f;
        logic [CNT_W-1:0]  quarter;
        logic [CNT_W-1:0]  half;
        logic [CNT_W-1:0]  three_q;
        logic [CNT_W-1:0]  late;
        logic [9:0]        tri_sum;
        logic [12:0]       late_num;
        logic [19:0]       late_prod;
        quarter   = {2'b00, hpd[7:2]};
        half      = {1'b0, hpd[7:1]};
        tri_sum   = {2'b00, hpd} + {1'b0, hpd, 1'b0};
        three_q   = tri_sum[9:2];
        late_num  = {5'd0, hpd} * {8'd0, LATE_NUM};
        late_prod = late_num[12:3] * DIV3_RECIP;
        late      = late_prod[DIV3_SHIFT+7:DIV3_SHIFT];
        f = '0;
        f[FLAG_NIGHT]     = (h < quarter) || (h >= three_q);
        f[FLAG_MORNING]   = (h >= quarter) && (h < half);
        f[FLAG_AFTERNOON] = (h >= half) && (h < three_q);
        f[FLAG_EVENING]   = (h >= three_q);
        f[FLAG_SLEEP]     = (h < quarter) || (h >= late);
        return f;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pcc_if.sv
// Valid/ready stream interfaces for the request and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface pcc_in_if;
    logic             valid;
    logic             ready;
    pcc_pkg::t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcc_out_if;
    logic              valid;
    logic              ready;
    pcc_pkg::t_out_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/programmable_calendar_counter_unit.sv
// Top level: programmable cascaded calendar counter with day-phase flags.
// A request's result sits in the result register the cycle after it is taken.
// Throughput: one request per cycle while ready is high; the six-stage carry ripple and the phase
// compares settle between the state registers and the result register.
// Ready holds high while the result register is empty or drains in the same cycle.
// Reset (synchronous, active low): counters and total clear, moduli take 60/60/24/7/4/12.
`timescale 1ns / 1ps
`default_nettype none

module programmable_calendar_counter_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [pcc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pcc_in_if.sink                             i_req,
    pcc_out_if.source                          o_rsp
);

    // Moduli
    logic [pcc_pkg::CNT_W-1:0] r_sec_mod, r_min_mod, r_hour_mod;
    logic [pcc_pkg::CNT_W-1:0] r_day_mod, r_week_mod, r_mon_mod;

    // Counter state and its next value
    logic [pcc_pkg::CNT_W-1:0]   r_sec, r_min, r_hour, r_day, r_week, r_mon;
    logic [pcc_pkg::YEAR_W-1:0]  r_year;
    logic [pcc_pkg::TOTAL_W-1:0] r_total;
    logic [pcc_pkg::CNT_W-1:0]   n_sec, n_min, n_hour, n_day, n_week, n_mon;
    logic [pcc_pkg::YEAR_W-1:0]  n_year;
    logic [pcc_pkg::TOTAL_W-1:0] n_total;

    // Result register
    logic              r_out_valid;
    pcc_pkg::t_out_rsp r_rsp;
    pcc_pkg::t_out_rsp n_rsp;

    logic in_accept;
    pcc_pkg::t_stage st_sec, st_min, st_hour, st_day, st_week, st_mon;

    // Take a request whenever the result slot is free or being drained.
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign in_accept   = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_mod  <= pcc_pkg::RST_SEC_PER_MIN;
            r_min_mod  <= pcc_pkg::RST_MIN_PER_HOUR;
            r_hour_mod <= pcc_pkg::RST_HOUR_PER_DAY;
            r_day_mod  <= pcc_pkg::RST_DAY_PER_WEEK;
            r_week_mod <= pcc_pkg::RST_WEEK_PER_MON;
            r_mon_mod  <= pcc_pkg::RST_MON_PER_YEAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcc_pkg::CFG_SEC_PER_MIN:  r_sec_mod  <= i_cfg_data;
                pcc_pkg::CFG_MIN_PER_HOUR: r_min_mod  <= i_cfg_data;
                pcc_pkg::CFG_HOUR_PER_DAY: r_hour_mod <= i_cfg_data;
                pcc_pkg::CFG_DAY_PER_WEEK: r_day_mod  <= i_cfg_data;
                pcc_pkg::CFG_WEEK_PER_MON: r_week_mod <= i_cfg_data;
                pcc_pkg::CFG_MON_PER_YEAR: r_mon_mod  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Tick carry ripple: each stage steps only if every stage below it wrapped.
    always_comb begin
        st_sec  = pcc_pkg::stage_step(r_sec, r_sec_mod);
        st_min  = pcc_pkg::stage_step(r_min, r_min_mod);
        st_hour = pcc_pkg::stage_step(r_hour, r_hour_mod);
        st_day  = pcc_pkg::stage_step(r_day, r_day_mod);
        st_week = pcc_pkg::stage_step(r_week, r_week_mod);
        st_mon  = pcc_pkg::stage_step(r_mon, r_mon_mod);

        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_week  = r_week;
        n_mon   = r_mon;
        n_year  = r_year;
        n_total = r_total;

        if (i_req.data.kind == pcc_pkg::KIND_SET) begin
            // Load the time as given; the running total holds.
            n_sec  = i_req.data.set_seconds;
            n_min  = i_req.data.set_minutes;
            n_hour = i_req.data.set_hours;
            n_day  = i_req.data.set_days;
            n_week = i_req.data.set_weeks;
            n_mon  = i_req.data.set_months;
            n_year = i_req.data.set_years;
        end else begin
            n_total = r_total + 32'd1;
            n_sec   = st_sec.count;
            if (st_sec.carry) begin
                n_min = st_min.count;
                if (st_min.carry) begin
                    n_hour = st_hour.count;
                    if (st_hour.carry) begin
                        n_day = st_day.count;
                        if (st_day.carry) begin
                            n_week = st_week.count;
                            if (st_week.carry) begin
                                n_mon = st_mon.count;
                                if (st_mon.carry) begin
                                    n_year = r_year + 16'd1;
                                end
                            end
                        end
                    end
                end
            end
        end

        n_rsp.cur_seconds     = n_sec;
        n_rsp.cur_minutes     = n_min;
        n_rsp.cur_hours       = n_hour;
        n_rsp.cur_days        = n_day;
        n_rsp.cur_weeks       = n_week;
        n_rsp.cur_months      = n_mon;
        n_rsp.cur_years       = n_year;
        n_rsp.elapsed_seconds = n_total;
        // Flags follow the hours after this request, loaded or counted.
        n_rsp.phase_flags     = pcc_pkg::phase_bits(n_hour, r_hour_mod);
    end

    // Register the next counter state on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec   <= '0;
            r_min   <= '0;
            r_hour  <= '0;
            r_day   <= '0;
            r_week  <= '0;
            r_mon   <= '0;
            r_year  <= '0;
            r_total <= '0;
        end else if (in_accept) begin
            r_sec   <= n_sec;
            r_min   <= n_min;
            r_hour  <= n_hour;
            r_day   <= n_day;
            r_week  <= n_week;
            r_mon   <= n_mon;
            r_year  <= n_year;
            r_total <= n_total;
        end
    end

    // Result register: fill on accept, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rsp <= n_rsp;
        end
    end

`ifndef SYNTHESIS
    a_tick_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req.data.kind == pcc_pkg::KIND_TICK)
            |=> (o_rsp.data.elapsed_seconds == $past(r_total) + 32'd1))
        else $error("tick did not advance the running total");

    a_set_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req.data.kind == pcc_pkg::KIND_SET)
            |=> (o_rsp.data.cur_hours == $past(i_req.data.set_hours)
                 && o_rsp.data.elapsed_seconds == $past(r_total)))
        else $error("set request did not load hours or disturbed total");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request refused with empty result register");

    a_night_complement: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rsp.phase_flags[pcc_pkg::FLAG_NIGHT] ==
            !(r_rsp.phase_flags[pcc_pkg::FLAG_MORNING]
              || r_rsp.phase_flags[pcc_pkg::FLAG_AFTERNOON])))
        else $error("night flag is not the complement of daytime");

    a_seconds_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_req.data.kind == pcc_pkg::KIND_TICK)
            |=> (r_sec == 8'd0 || r_sec == $past(r_sec) + 8'd1))
        else $error("seconds stage moved by other than one step");
`endif

endmodule

`default_nettype wire
